// ----- hw/rtl/xce_pkg.sv -----
// Package for the XML character escaper: character classes, entity text and
// per-class run lengths. No dependencies.
package xce_pkg;

  localparam int unsigned ByteW = 8;
  localparam int unsigned MaxRun = 6;
  localparam int unsigned IdxW = $clog2(MaxRun);
  localparam int unsigned LenW = $clog2(MaxRun + 1);

  localparam logic [ByteW-1:0] CtrlLimit = 8'h20;
  localparam logic [ByteW-1:0] SpaceByte = 8'h20;

  localparam logic [ByteW-1:0] ChrAmp  = 8'h26;
  localparam logic [ByteW-1:0] ChrLt   = 8'h3C;
  localparam logic [ByteW-1:0] ChrGt   = 8'h3E;
  localparam logic [ByteW-1:0] ChrQuot = 8'h22;
  localparam logic [ByteW-1:0] ChrApos = 8'h27;
  localparam logic [ByteW-1:0] ChrCr   = 8'h0D;
  localparam logic [ByteW-1:0] ChrLf   = 8'h0A;
  localparam logic [ByteW-1:0] ChrTab  = 8'h09;

  // Entity text, left aligned: element 5 holds the first character.
  localparam logic [MaxRun-1:0][ByteW-1:0] TxtAmp  = {"&amp;", 8'h00};
  localparam logic [MaxRun-1:0][ByteW-1:0] TxtLt   = {"&lt;", 16'h0000};
  localparam logic [MaxRun-1:0][ByteW-1:0] TxtGt   = {"&gt;", 16'h0000};
  localparam logic [MaxRun-1:0][ByteW-1:0] TxtQuot = "&quot;";
  localparam logic [MaxRun-1:0][ByteW-1:0] TxtApos = "&apos;";
  localparam logic [MaxRun-1:0][ByteW-1:0] TxtNl   = {"&#10;", 8'h00};
  localparam logic [MaxRun-1:0][ByteW-1:0] TxtTab  = {"&#9;", 16'h0000};

  typedef enum logic [3:0] {
    CLS_PASS,
    CLS_SPACE,
    CLS_AMP,
    CLS_LT,
    CLS_GT,
    CLS_QUOT,
    CLS_APOS,
    CLS_NL,
    CLS_TAB
  } cls_e;

  // One output symbol of a run, plus the run length for checking.
  typedef struct packed {
    logic [ByteW-1:0] chr;
    logic             last;
    logic [LenW-1:0]  len;
  } sym_t;

  function automatic cls_e classify(input logic [ByteW-1:0] b);
    cls_e c;
    case (b)
      ChrAmp:        c = CLS_AMP;
      ChrLt:         c = CLS_LT;
      ChrGt:         c = CLS_GT;
      ChrQuot:       c = CLS_QUOT;
      ChrApos:       c = CLS_APOS;
      ChrCr, ChrLf:  c = CLS_NL;
      ChrTab:        c = CLS_TAB;
      default:       c = (b < CtrlLimit) ? CLS_SPACE : CLS_PASS;
    endcase
    return c;
  endfunction

  function automatic logic [LenW-1:0] run_len(input cls_e c);
    logic [LenW-1:0] n;
    case (c)
      CLS_AMP, CLS_NL:           n = LenW'(5);
      CLS_LT, CLS_GT, CLS_TAB:   n = LenW'(4);
      CLS_QUOT, CLS_APOS:        n = LenW'(6);
      default:                   n = LenW'(1);
    endcase
    return n;
  endfunction

endpackage

// ----- hw/rtl/xce_map.sv -----
// Combinational map from a raw byte and a position in its run to one
// escaped output byte. Depends on xce_pkg.
module xce_map (
  input  logic [xce_pkg::ByteW-1:0] byte_i,
  input  logic [xce_pkg::IdxW-1:0]  idx_i,
  output xce_pkg::sym_t             sym_o
);
  import xce_pkg::*;

  cls_e                          cls;
  logic [MaxRun-1:0][ByteW-1:0]  txt;
  logic [IdxW-1:0]               pos;

  assign cls = classify(byte_i);
  // Text is stored left aligned, so walk it from the top element down.
  assign pos = IdxW'(MaxRun - 1) - idx_i;

  always_comb begin
    case (cls)
      CLS_AMP:  txt = TxtAmp;
      CLS_LT:   txt = TxtLt;
      CLS_GT:   txt = TxtGt;
      CLS_QUOT: txt = TxtQuot;
      CLS_APOS: txt = TxtApos;
      CLS_NL:   txt = TxtNl;
      CLS_TAB:  txt = TxtTab;
      default:  txt = '0;
    endcase
  end

  always_comb begin
    sym_o.len  = run_len(cls);
    sym_o.last = (LenW'(idx_i) == (sym_o.len - LenW'(1)));
    case (cls)
      CLS_PASS:  sym_o.chr = byte_i;
      CLS_SPACE: sym_o.chr = SpaceByte;
      default:   sym_o.chr = txt[pos];
    endcase
  end

endmodule

// ----- hw/rtl/xml_char_escaper_unit.sv -----
// Top level of the XML character escaper: input word register with run
// position counter, symbol map, output word register. Depends on xce_pkg, xce_map.
//
// One input word carries one text byte; the block answers with its escaped
// form as a run of one to six output words, run_last_o marking the final word
// of each run. The five XML specials become named entities, CR and LF become
// "&#10;", tab becomes "&#9;", other bytes below 0x20 become a space, and every
// other byte (0x80 and up included) passes through unchanged. Throughput is
// one output word per cycle while out_stall_i is low, set by the single output
// register: a plain byte yields one output word, an escaped byte as many words
// as its entity has characters (4 to 6). A new input word is taken in the same
// cycle the last word of the previous run moves to the output register, so
// plain text streams at one byte per clock while the output is not stalled.
// The first output word of a run is held in the input word register and then
// loaded into the output word register once that is empty or being drained.
// There is no state beyond the words in flight.
module xml_char_escaper_unit (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_stall_o,
  input  logic [xce_pkg::ByteW-1:0] in_byte_i,
  output logic                      out_valid_o,
  input  logic                      out_stall_i,
  output logic [xce_pkg::ByteW-1:0] out_byte_o,
  output logic                      run_last_o
);
  import xce_pkg::*;

  // Input stage: held byte and position within its run.
  logic             s1_valid_q;
  logic [ByteW-1:0] s1_byte_q;
  logic [IdxW-1:0]  idx_q;

  // Output stage.
  logic             out_valid_q;
  logic [ByteW-1:0] out_byte_q;
  logic             out_last_q;

  sym_t sym;
  logic out_load;
  logic s1_done;
  logic in_take;

  xce_map u_map (
    .byte_i (s1_byte_q),
    .idx_i  (idx_q),
    .sym_o  (sym)
  );

  // Output register takes a new word when empty or being drained.
  assign out_load = !out_valid_q || !out_stall_i;
  // Last word of the run moves out: free the input stage.
  assign s1_done  = s1_valid_q && out_load && sym.last;
  assign in_stall_o = s1_valid_q && !s1_done;
  assign in_take  = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_take) begin
        s1_valid_q <= 1'b1;
        idx_q      <= '0;
      end else if (s1_done) begin
        s1_valid_q <= 1'b0;
      end else if (s1_valid_q && out_load) begin
        // Advance to the next character of the entity.
        idx_q <= idx_q + IdxW'(1);
      end
      if (out_load) begin
        out_valid_q <= s1_valid_q;
      end
    end
  end

  // Payload: hold unless loading.
  always_ff @(posedge clk_i) begin
    if (in_take) begin
      s1_byte_q <= in_byte_i;
    end
    if (out_load && s1_valid_q) begin
      out_byte_q <= sym.chr;
      out_last_q <= sym.last;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_byte_o  = out_byte_q;
  assign run_last_o  = out_last_q;

  // Run position never passes the end of the entity.
  a_idx_in_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q |-> (LenW'(idx_q) < sym.len))
    else $error("run position beyond entity length");

  // A new word enters only when the stage is empty or finishing its run.
  a_take_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_take |-> (!s1_valid_q || s1_done))
    else $error("input word accepted over a run in progress");

  // A loaded symbol shows up at the output the next cycle.
  a_load_shows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && out_load) |=> out_valid_o)
    else $error("symbol loaded but output not valid");

  // Escaped text never carries a control byte.
  a_no_ctrl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_byte_o >= CtrlLimit))
    else $error("control byte on output");

endmodule
